>>> design/wcp_pkg.sv
// Shared constants for the wall column projection block.
// No dependencies; imported by the top level and the divider.
`default_nettype none
package wcp_pkg;

  localparam logic [23:0] DIST_MAX   = 24'hFFFFFF;
  localparam logic [15:0] LH_MAX     = 16'hFFFF;
  localparam logic [25:0] STEP_MAX   = 26'h3FFFFFF;
  localparam logic [9:0]  TEXCOL_MAX = 10'd1023;

  localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;

  // Register index of screen_height in the configuration map.
  localparam logic REG_SCREEN_HEIGHT = 1'b0;

  // Divider geometry: divisor width, quotient bits (one stage per bit).
  localparam int unsigned DIV1_DW = 18;
  localparam int unsigned DIV1_QW = 24;
  localparam int unsigned DIV2_DW = 24;
  localparam int unsigned DIV2_QW = 16;
  localparam int unsigned DIV3_DW = 16;
  localparam int unsigned DIV3_QW = 27;

  // How the wall distance is formed after the first divider.
  typedef enum logic [1:0] {
    DS_QUO,
    DS_MAX,
    DS_ZERO
  } dsel_t;

endpackage
`default_nettype wire

>>> design/wcp_pipe_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Uses wcp_pkg for the default geometry; carries a sideband vector.
`default_nettype none
module wcp_pipe_div
  import wcp_pkg::*;
#(
  parameter int unsigned DW  = DIV1_DW,
  parameter int unsigned QW  = DIV1_QW,
  parameter int unsigned SBW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [DW-1:0]  in_rem,
  input  wire logic [QW-1:0]  in_num,
  input  wire logic [DW-1:0]  in_div,
  input  wire logic [SBW-1:0] in_sb,
  output logic                out_valid,
  output logic [QW-1:0]       out_quo,
  output logic [SBW-1:0]      out_sb
);

  // The starting remainder must be below the divisor; the dividend's
  // remaining low bits enter MSB first, one per stage.
  logic [DW-1:0]  rem_r [1:QW];
  logic [DW-1:0]  div_r [1:QW];
  logic [QW-1:0]  num_r [1:QW];
  logic [QW-1:0]  quo_r [1:QW];
  logic [SBW-1:0] sb_r  [1:QW];
  logic           vld_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0]  rem_i;
    logic [DW-1:0]  div_i;
    logic [QW-1:0]  num_i;
    logic [QW-1:0]  quo_i;
    logic [SBW-1:0] sb_i;
    logic           vld_i;
    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_i = in_rem;
      assign div_i = in_div;
      assign num_i = in_num;
      assign quo_i = '0;
      assign sb_i  = in_sb;
      assign vld_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_r[k];
      assign div_i = div_r[k];
      assign num_i = num_r[k];
      assign quo_i = quo_r[k];
      assign sb_i  = sb_r[k];
      assign vld_i = vld_r[k];
    end

    assign trial = {rem_i, num_i[QW-1]};
    assign diff  = trial - {1'b0, div_i};
    assign ge    = (trial >= {1'b0, div_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        div_r[k+1] <= div_i;
        num_r[k+1] <= {num_i[QW-2:0], 1'b0};
        quo_r[k+1] <= {quo_i[QW-2:0], ge};
        sb_r[k+1]  <= sb_i;
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_sb    = sb_r[QW];

endmodule
`default_nettype wire

>>> design/wall_column_projection.sv
// Top level of the wall column projection pipeline.
// Depends on wcp_pkg and wcp_pipe_div.
//
//   channel  | direction | handshake            | beat carries
//   ---------+-----------+----------------------+-------------------------------
//   in_      | input     | in_valid / in_stall  | one finished DDA hit
//   out_     | output    | out_valid / out_stall| one projected wall slice
//   cfg (APB)| input     | psel/penable/pready  | screen_height at address 0
//
// A beat enters every clock unless a valid output beat is stalled, and
// passes through a prep stage, the 24-stage distance divider, a stage, the
// 16-stage line height divider, a stage, the 27-stage texture step divider,
// a texture stage and the output register.
// Reset (synchronous, active low) clears every valid bit and loads the
// screen height with 480. A stall on a valid output freezes the whole pipe
// in place, so nothing is dropped or repeated; in_stall follows that freeze.
`default_nettype none
module wall_column_projection
  import wcp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [10:0]        in_column,
  input  wire logic               in_side,
  input  wire logic [7:0]         in_map_cell_x,
  input  wire logic [7:0]         in_map_cell_y,
  input  wire logic [23:0]        in_pos_x,
  input  wire logic [23:0]        in_pos_y,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic [10:0]        in_tex_width,
  input  wire logic [10:0]        in_tex_height,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [10:0]             out_column_out,
  output logic [23:0]             out_wall_dist,
  output logic [15:0]             out_line_height,
  output logic [10:0]             out_draw_start,
  output logic [15:0]             out_draw_end,
  output logic [9:0]              out_tex_column,
  output logic [25:0]             out_tex_step,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  // Sideband that rides along each divider.
  typedef struct packed {
    logic [10:0]        col;
    logic [23:0]        opos;
    logic signed [17:0] odir;
    logic [10:0]        tw;
    logic [10:0]        th;
    logic               mirror;
    dsel_t              dsel;
  } sb1_t;

  typedef struct packed {
    logic [10:0] col;
    logic [23:0] wdist;
    logic        ovf;
    logic [15:0] opos_lo;
    logic [31:0] prod;
    logic [10:0] tw;
    logic [10:0] th;
    logic        mirror;
  } sb2_t;

  typedef struct packed {
    logic [10:0] col;
    logic [23:0] wdist;
    logic [15:0] lh;
    logic [10:0] ds;
    logic [15:0] de;
    logic [31:0] frac;
    logic [10:0] tw;
    logic        mirror;
  } sb3_t;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [10:0] height_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr && (paddr[2] == REG_SCREEN_HEIGHT)) begin
      height_r <= pwdata[10:0];
    end
  end

  assign prdata = (paddr[2] == REG_SCREEN_HEIGHT) ? {21'd0, height_r} : 32'd0;

  // ---------------------------------------------------------------------
  // Global advance: the pipe moves unless a finished beat is held up.
  // ---------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // ---------------------------------------------------------------------
  // Prep stage: pick the hit axis, form the numerator and classify it.
  // The quotient fits 24 bits exactly when the magnitude is below
  // 256 times the divisor, so that compare decides saturation up front.
  // ---------------------------------------------------------------------
  logic [7:0]         cell_c;
  logic [23:0]        pos_c;
  logic signed [17:0] dir_c;
  logic signed [25:0] num_c;
  logic [24:0]        mag_c;
  logic [17:0]        dmag_c;
  logic               neg_c;
  logic               mirror_c;
  dsel_t              dsel_c;

  assign cell_c = in_side ? in_map_cell_y : in_map_cell_x;
  assign pos_c  = in_side ? in_pos_y : in_pos_x;
  assign dir_c  = in_side ? in_ray_dir_y : in_ray_dir_x;

  assign num_c = $signed({2'b00, cell_c, 16'h0000}) - $signed({2'b00, pos_c})
               + (dir_c[17] ? 26'sd65536 : 26'sd0);
  assign mag_c  = num_c[25] ? 25'(-num_c) : num_c[24:0];
  assign dmag_c = dir_c[17] ? 18'(~dir_c + 18'sd1) : dir_c;
  assign neg_c  = num_c[25] != dir_c[17];

  always_comb begin
    priority if (dir_c == 18'sd0) begin
      dsel_c = DS_MAX;
    end else if (neg_c || (mag_c == 25'd0)) begin
      dsel_c = DS_ZERO;
    end else if ({1'b0, mag_c} >= {dmag_c, 8'h00}) begin
      dsel_c = DS_MAX;
    end else begin
      dsel_c = DS_QUO;
    end
  end

  // Mirror when an x-facing wall is seen moving right, or a y-facing one
  // moving up the map.
  assign mirror_c = in_side ? in_ray_dir_y[17]
                            : (!in_ray_dir_x[17] && (in_ray_dir_x != 18'sd0));

  logic                s0_vld_r;
  logic [DIV1_DW-1:0]  s0_rem_r;
  logic [DIV1_QW-1:0]  s0_num_r;
  logic [DIV1_DW-1:0]  s0_div_r;
  sb1_t                s0_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_rem_r       <= DIV1_DW'(mag_c[24:8]);
      s0_num_r       <= {mag_c[7:0], 16'h0000};
      s0_div_r       <= dmag_c;
      s0_sb_r.col    <= in_column;
      s0_sb_r.opos   <= in_side ? in_pos_x : in_pos_y;
      s0_sb_r.odir   <= in_side ? in_ray_dir_x : in_ray_dir_y;
      s0_sb_r.tw     <= in_tex_width;
      s0_sb_r.th     <= in_tex_height;
      s0_sb_r.mirror <= mirror_c;
      s0_sb_r.dsel   <= dsel_c;
    end
  end

  // ---------------------------------------------------------------------
  // Divider 1: wall distance = (magnitude << 16) / |direction|
  // ---------------------------------------------------------------------
  logic               d1_vld;
  logic [DIV1_QW-1:0] d1_quo;
  sb1_t               d1_sb;

  wcp_pipe_div #(
    .DW  (DIV1_DW),
    .QW  (DIV1_QW),
    .SBW ($bits(sb1_t))
  ) u_div_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .in_rem    (s0_rem_r),
    .in_num    (s0_num_r),
    .in_div    (s0_div_r),
    .in_sb     (s0_sb_r),
    .out_valid (d1_vld),
    .out_quo   (d1_quo),
    .out_sb    (d1_sb)
  );

  // ---------------------------------------------------------------------
  // Stage 1: settle the distance, start the wall hit product, and check
  // whether the line height saturates (height >= distance).
  // ---------------------------------------------------------------------
  logic [23:0]        dist_c;
  logic signed [42:0] prod_c;

  always_comb begin
    unique case (d1_sb.dsel)
      DS_MAX:  dist_c = DIST_MAX;
      DS_ZERO: dist_c = 24'd0;
      default: dist_c = d1_quo;
    endcase
  end

  assign prod_c = $signed({1'b0, dist_c}) * $signed(d1_sb.odir);

  logic               s1_vld_r;
  sb2_t               s1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sb_r.col     <= d1_sb.col;
      s1_sb_r.wdist   <= dist_c;
      s1_sb_r.ovf     <= ({13'd0, height_r} >= dist_c);
      s1_sb_r.opos_lo <= d1_sb.opos[15:0];
      s1_sb_r.prod    <= prod_c[31:0];
      s1_sb_r.tw      <= d1_sb.tw;
      s1_sb_r.th      <= d1_sb.th;
      s1_sb_r.mirror  <= d1_sb.mirror;
    end
  end

  // ---------------------------------------------------------------------
  // Divider 2: line height = (screen_height << 16) / distance
  // ---------------------------------------------------------------------
  logic               d2_vld;
  logic [DIV2_QW-1:0] d2_quo;
  sb2_t               d2_sb;

  wcp_pipe_div #(
    .DW  (DIV2_DW),
    .QW  (DIV2_QW),
    .SBW ($bits(sb2_t))
  ) u_div_height (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_vld_r),
    .in_rem    ({13'd0, height_r}),
    .in_num    ('0),
    .in_div    (s1_sb_r.wdist),
    .in_sb     (s1_sb_r),
    .out_valid (d2_vld),
    .out_quo   (d2_quo),
    .out_sb    (d2_sb)
  );

  // ---------------------------------------------------------------------
  // Stage 2: final line height, draw rows and the texture fraction.
  // ---------------------------------------------------------------------
  logic [15:0] lh_c;
  logic [14:0] lh_half_c;
  logic [9:0]  h_half_c;
  logic [15:0] de_sum_c;
  logic [10:0] ds_c;
  logic [15:0] de_c;

  always_comb begin
    priority if (d2_sb.ovf) begin
      lh_c = LH_MAX;
    end else if (d2_quo == '0) begin
      lh_c = 16'd1;
    end else begin
      lh_c = d2_quo;
    end
  end

  assign lh_half_c = lh_c[15:1];
  assign h_half_c  = height_r[10:1];
  assign de_sum_c  = {1'b0, lh_half_c} + {6'd0, h_half_c};
  assign ds_c      = (lh_half_c > {5'd0, h_half_c}) ? 11'd0
                   : {1'b0, h_half_c - lh_half_c[9:0]};

  always_comb begin
    priority if (de_sum_c < {5'd0, height_r}) begin
      de_c = de_sum_c;
    end else if (height_r == 11'd0) begin
      de_c = 16'd0;
    end else begin
      de_c = {5'd0, height_r - 11'd1};
    end
  end

  logic               s2_vld_r;
  logic [10:0]        s2_th_r;
  sb3_t               s2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_th_r        <= d2_sb.th;
      s2_sb_r.col    <= d2_sb.col;
      s2_sb_r.wdist  <= d2_sb.wdist;
      s2_sb_r.lh     <= lh_c;
      s2_sb_r.ds     <= ds_c;
      s2_sb_r.de     <= de_c;
      s2_sb_r.frac   <= {d2_sb.opos_lo, 16'h0000} + d2_sb.prod;
      s2_sb_r.tw     <= d2_sb.tw;
      s2_sb_r.mirror <= d2_sb.mirror;
    end
  end

  // ---------------------------------------------------------------------
  // Divider 3: texture step = (tex_height << 16) / line height
  // ---------------------------------------------------------------------
  logic               d3_vld;
  logic [DIV3_QW-1:0] d3_quo;
  sb3_t               d3_sb;

  wcp_pipe_div #(
    .DW  (DIV3_DW),
    .QW  (DIV3_QW),
    .SBW ($bits(sb3_t))
  ) u_div_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s2_vld_r),
    .in_rem    ('0),
    .in_num    ({s2_th_r, 16'h0000}),
    .in_div    (s2_sb_r.lh),
    .in_sb     (s2_sb_r),
    .out_valid (d3_vld),
    .out_quo   (d3_quo),
    .out_sb    (d3_sb)
  );

  // ---------------------------------------------------------------------
  // Stage 3: texel column = top bits of fraction times texture width.
  // ---------------------------------------------------------------------
  logic [42:0] texprod_c;

  assign texprod_c = d3_sb.frac * d3_sb.tw;

  logic        s3_vld_r;
  logic [10:0] s3_texraw_r;
  logic [25:0] s3_step_r;
  sb3_t        s3_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= d3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_texraw_r <= texprod_c[42:32];
      s3_step_r   <= d3_quo[DIV3_QW-1] ? STEP_MAX : d3_quo[25:0];
      s3_sb_r     <= d3_sb;
    end
  end

  // ---------------------------------------------------------------------
  // Output register: mirror and clamp the texture column.
  // ---------------------------------------------------------------------
  logic [10:0] tex_c;
  logic [9:0]  texcol_c;

  always_comb begin
    priority if (s3_sb_r.tw == 11'd0) begin
      tex_c = 11'd0;
    end else if (s3_sb_r.mirror) begin
      tex_c = s3_sb_r.tw - s3_texraw_r - 11'd1;
    end else begin
      tex_c = s3_texraw_r;
    end
  end

  assign texcol_c = tex_c[10] ? TEXCOL_MAX : tex_c[9:0];

  logic [10:0] col_r;
  logic [23:0] dist_r;
  logic [15:0] lh_r;
  logic [10:0] ds_r;
  logic [15:0] de_r;
  logic [9:0]  texcol_r;
  logic [25:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r    <= s3_sb_r.col;
      dist_r   <= s3_sb_r.wdist;
      lh_r     <= s3_sb_r.lh;
      ds_r     <= s3_sb_r.ds;
      de_r     <= s3_sb_r.de;
      texcol_r <= texcol_c;
      step_r   <= s3_step_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column_out  = col_r;
  assign out_wall_dist   = dist_r;
  assign out_line_height = lh_r;
  assign out_draw_start  = ds_r;
  assign out_draw_end    = de_r;
  assign out_tex_column  = texcol_r;
  assign out_tex_step    = step_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_zero_dist_full_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (dist_r == 24'd0) |-> (lh_r == LH_MAX))
    else $error("zero distance must give full line height");

  a_height_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (lh_r != 16'd0))
    else $error("line height must be at least one");

  a_start_in_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (ds_r[10] == 1'b0))
    else $error("draw start beyond half the largest screen");

  a_step_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r && en && (s3_sb_r.lh == 16'd1) && (s3_step_r != STEP_MAX)
    |=> (step_r[25:16] == $past(s3_step_r[25:16])))
    else $error("texture step lost on the way to the output");

endmodule
`default_nettype wire
